/* rtl/flow_table_packet_counter_unit_defines.svh */
// ---------------------------------------------------------------------------
// flow table packet counter - assertion macros
// shared concurrent assertion forms, clocked on clk and held off in reset
// ---------------------------------------------------------------------------
`ifndef FLOW_TABLE_PACKET_COUNTER_UNIT_DEFINES_SVH
`define FLOW_TABLE_PACKET_COUNTER_UNIT_DEFINES_SVH

// property checked at every rising edge outside reset
`define FTPC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// implication checked at every rising edge outside reset
`define FTPC_ASSERT_IMPL(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

`endif

/* rtl/ftpc_pkg.sv */
// ---------------------------------------------------------------------------
// ftpc_pkg
// types, widths and codes shared by the flow table packet counter modules
// ---------------------------------------------------------------------------
package ftpc_pkg;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int COUNT_W  = 32;
    localparam int SLOT_W   = 7;
    localparam int STATUS_W = 3;

    // operation codes
    localparam logic OP_DATA  = 1'b0;
    localparam logic OP_CLOSE = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_ADDED   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_REMOVED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

    typedef struct packed {
        logic              is_close;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
    } cmd_t;

    typedef struct packed {
        logic [ADDR_W-1:0]  addr;
        logic [PORT_W-1:0]  port;
        logic [COUNT_W-1:0] count;
    } entry_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  count;
    } res_t;

    // saturating packet counter increment
    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] c);
        logic [COUNT_W-1:0] r;
        r = (c == {COUNT_W{1'b1}}) ? c : c + COUNT_W'(1);
        return r;
    endfunction

endpackage

/* rtl/ftpc_front.sv */
// ---------------------------------------------------------------------------
// ftpc_front
// accepts packet transactions, classifies them and holds them in a
// two-entry command queue for the table engine
// ---------------------------------------------------------------------------
module ftpc_front (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         push,
    output logic                         full,
    input  logic                         operation,
    input  logic [ftpc_pkg::ADDR_W-1:0]  source_address,
    input  logic [ftpc_pkg::PORT_W-1:0]  source_port,
    output logic                         cmd_valid,
    input  logic                         cmd_take,
    output ftpc_pkg::cmd_t               cmd
);
    import ftpc_pkg::*;

    cmd_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;
    cmd_t       in_cmd;

    // classify the incoming transaction
    always_comb
    begin
        in_cmd.is_close = (operation == OP_CLOSE);
        in_cmd.addr     = source_address;
        in_cmd.port     = source_port;
    end

    assign full      = (cnt_reg == 2'd2);
    assign cmd_valid = (cnt_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* rtl/ftpc_result_q.sv */
// ---------------------------------------------------------------------------
// ftpc_result_q
// two-entry result queue between the table engine and the result port
// ---------------------------------------------------------------------------
module ftpc_result_q (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           res_push,
    input  ftpc_pkg::res_t res_in,
    output logic           res_full,
    output logic           empty,
    input  logic           pop,
    output ftpc_pkg::res_t head
);
    import ftpc_pkg::*;

    res_t       q_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       do_push;
    logic       do_pop;

    assign res_full = (cnt_reg == 2'd2);
    assign empty    = (cnt_reg == 2'd0);
    assign head     = q_reg[rd_ptr_reg];
    assign do_push  = res_push && !res_full;
    assign do_pop   = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            q_reg[wr_ptr_reg] <= res_in;
        end
    end

endmodule

/* rtl/ftpc_engine.sv */
// ---------------------------------------------------------------------------
// ftpc_engine
// table engine: scans the flow memory one entry a cycle, counts, appends
// and removes flows with an order-keeping shift
// ---------------------------------------------------------------------------
`include "flow_table_packet_counter_unit_defines.svh"

module ftpc_engine (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cmd_valid,
    output logic           cmd_take,
    input  ftpc_pkg::cmd_t cmd,
    output logic           res_push,
    output ftpc_pkg::res_t res_out,
    input  logic           res_full
);
    import ftpc_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SEARCH = 2'd1;
    localparam logic [1:0] S_SHIFT  = 2'd2;
    localparam logic [1:0] S_FINISH = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CNT_W-1:0] ptr_reg;
    logic [CNT_W-1:0] ptr_next;
    logic [CNT_W-1:0] occ_reg;
    logic [CNT_W-1:0] occ_next;
    cmd_t             cur_reg;
    cmd_t             cur_next;
    res_t             res_reg;
    res_t             res_next;

    // flow memory, one write and one registered read per cycle
    entry_t           mem [TABLE_DEPTH];
    entry_t           rd_data_reg;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    entry_t           mem_wdata;
    logic [IDX_W-1:0] mem_raddr;

    logic [CNT_W-1:0]   ptr_inc;
    logic [CNT_W-1:0]   ptr_add2;
    logic               key_hit;
    logic               scan_last;
    logic [COUNT_W-1:0] hit_count;

    assign ptr_inc   = ptr_reg + CNT_W'(1);
    assign ptr_add2  = ptr_reg + CNT_W'(2);
    assign key_hit   = (ptr_reg < occ_reg) && (rd_data_reg.addr == cur_reg.addr)
                       && (rd_data_reg.port == cur_reg.port);
    assign scan_last = (ptr_inc >= occ_reg);
    assign hit_count = sat_inc(rd_data_reg.count);
    assign res_out   = res_reg;

    always_comb
    begin
        state_next = state_reg;
        ptr_next   = ptr_reg;
        occ_next   = occ_reg;
        cur_next   = cur_reg;
        res_next   = res_reg;
        mem_we     = 1'b0;
        mem_waddr  = IDX_W'(ptr_reg);
        mem_wdata  = rd_data_reg;
        mem_raddr  = IDX_W'(ptr_inc);
        cmd_take   = 1'b0;
        res_push   = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                mem_raddr = '0;
                if (cmd_valid)
                begin
                    cmd_take   = 1'b1;
                    cur_next   = cmd;
                    ptr_next   = '0;
                    state_next = S_SEARCH;
                end
            end

            S_SEARCH:
            begin
                // rd_data_reg holds entry ptr, entry ptr+1 is being read
                if (key_hit)
                begin
                    if (!cur_reg.is_close)
                    begin
                        mem_we     = 1'b1;
                        mem_wdata  = '{addr: cur_reg.addr, port: cur_reg.port,
                                       count: hit_count};
                        res_next   = '{status: ST_COUNTED, slot: SLOT_W'(ptr_reg),
                                       count: hit_count};
                        state_next = S_FINISH;
                    end
                    else if (scan_last)
                    begin
                        occ_next   = occ_reg - CNT_W'(1);
                        res_next   = '{status: ST_REMOVED, slot: '0, count: '0};
                        state_next = S_FINISH;
                    end
                    else
                    begin
                        state_next = S_SHIFT;
                    end
                end
                else if (scan_last)
                begin
                    if (cur_reg.is_close)
                    begin
                        res_next = '{status: ST_IGNORED, slot: '0, count: '0};
                    end
                    else if (occ_reg == CNT_W'(TABLE_DEPTH))
                    begin
                        res_next = '{status: ST_FULL, slot: '0, count: '0};
                    end
                    else
                    begin
                        // append a new flow, its first packet makes the count one
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(occ_reg);
                        mem_wdata = '{addr: cur_reg.addr, port: cur_reg.port,
                                      count: COUNT_W'(1)};
                        occ_next  = occ_reg + CNT_W'(1);
                        res_next  = '{status: ST_ADDED, slot: SLOT_W'(occ_reg),
                                      count: COUNT_W'(1)};
                    end
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end

            S_SHIFT:
            begin
                // move entry ptr+1 down into ptr, fetch ptr+2
                mem_we    = 1'b1;
                mem_raddr = IDX_W'(ptr_add2);
                if (ptr_add2 >= occ_reg)
                begin
                    occ_next   = occ_reg - CNT_W'(1);
                    res_next   = '{status: ST_REMOVED, slot: '0, count: '0};
                    state_next = S_FINISH;
                end
                else
                begin
                    ptr_next = ptr_inc;
                end
            end

            S_FINISH:
            begin
                if (!res_full)
                begin
                    res_push   = 1'b1;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            occ_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            occ_reg   <= occ_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    `FTPC_ASSERT(a_occ_bound, occ_reg <= CNT_W'(TABLE_DEPTH), "occupancy above table depth")
    `FTPC_ASSERT_IMPL(a_shift_range, state_reg == S_SHIFT, ptr_inc < occ_reg, "shift past last entry")
    `FTPC_ASSERT_IMPL(a_occ_change, occ_reg != $past(occ_reg), state_reg == S_FINISH, "occupancy moved outside a finish")
    `FTPC_ASSERT_IMPL(a_count_nonzero, res_push && (res_reg.status == ST_COUNTED || res_reg.status == ST_ADDED), res_reg.count != '0, "counted flow reports zero")

endmodule

/* rtl/flow_table_packet_counter_unit.sv */
// path: a transaction passes the front queue, the engine search (and shift for a removal),
//   the engine result register and the result queue before it reaches the result ports
// throughput: one transaction at a time in the table engine; the flow memory gives one
//   read and one write per cycle
// reset: rst_n asynchronous active low, clears both queues and the occupancy, table contents kept
// ---------------------------------------------------------------------------
// flow_table_packet_counter_unit
// exact-match flow table keyed by ipv4 source address and udp port, with
// a saturating packet counter per flow
// ---------------------------------------------------------------------------
module flow_table_packet_counter_unit (
    input  logic                           clk,
    input  logic                           rst_n,
    // packet transactions
    input  logic                           push,
    output logic                           full,
    input  logic                           operation,
    input  logic [ftpc_pkg::ADDR_W-1:0]    source_address,
    input  logic [ftpc_pkg::PORT_W-1:0]    source_port,
    // result transactions
    output logic                           empty,
    input  logic                           pop,
    output logic [ftpc_pkg::STATUS_W-1:0]  status,
    output logic [ftpc_pkg::SLOT_W-1:0]    slot,
    output logic [ftpc_pkg::COUNT_W-1:0]   packet_count
);
    import ftpc_pkg::*;

    // front to engine command path
    logic cmd_valid;
    logic cmd_take;
    cmd_t cmd;

    // engine to result queue path
    logic res_push;
    logic res_full;
    res_t res_in;
    res_t head;

    // front: accepts and classifies, decoupled from the engine by its queue
    ftpc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .source_address (source_address),
        .source_port    (source_port),
        .cmd_valid      (cmd_valid),
        .cmd_take       (cmd_take),
        .cmd            (cmd)
    );

    // back: search, count, append and order-keeping remove on the flow memory
    ftpc_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .res_push  (res_push),
        .res_out   (res_in),
        .res_full  (res_full)
    );

    // results wait here so a stalled consumer does not hold the engine until the queue is full
    ftpc_result_q u_result_q (
        .clk      (clk),
        .rst_n    (rst_n),
        .res_push (res_push),
        .res_in   (res_in),
        .res_full (res_full),
        .empty    (empty),
        .pop      (pop),
        .head     (head)
    );

    // oldest result drives the result ports
    assign status       = head.status;
    assign slot         = head.slot;
    assign packet_count = head.count;

endmodule

/* test/flow_table_packet_counter_checker.sv */
// ---------------------------------------------------------------------------
// flow table packet counter checker
// watches the packet and result transactions, keeps its own flow table and
// compares every popped result field by field with the oldest prediction
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module flow_table_packet_counter_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic                          full,
    input  logic                          operation,
    input  logic [ftpc_pkg::ADDR_W-1:0]   source_address,
    input  logic [ftpc_pkg::PORT_W-1:0]   source_port,
    input  logic                          empty,
    input  logic                          pop,
    input  logic [ftpc_pkg::STATUS_W-1:0] status,
    input  logic [ftpc_pkg::SLOT_W-1:0]   slot,
    input  logic [ftpc_pkg::COUNT_W-1:0]  packet_count,
    output int                            mismatch_count,
    output int                            results_outstanding
);
    import ftpc_pkg::*;

    localparam int MAX_PRINTED = 40;

    // shadow flow table, dense and ordered like the block's own
    logic [ADDR_W-1:0]  flow_addr    [TABLE_DEPTH];
    logic [PORT_W-1:0]  flow_port    [TABLE_DEPTH];
    logic [COUNT_W-1:0] flow_packets [TABLE_DEPTH];
    int                 flow_total = 0;

    res_t expected_results [$];
    res_t oldest;
    int   result_index = 0;

    initial mismatch_count = 0;
    initial results_outstanding = 0;

    task automatic report_mismatch(input string what, input logic [63:0] want,
                                   input logic [63:0] got);
        if (mismatch_count < MAX_PRINTED)
            $display("mismatch at %0t, result %0d: %s expected %0h got %0h",
                     $time, result_index, what, want, got);
        mismatch_count++;
    endtask

    // applies one packet transaction to the shadow table and returns its result
    function automatic res_t apply_packet(input logic op, input logic [ADDR_W-1:0] addr,
                                          input logic [PORT_W-1:0] port);
        res_t r;
        int   hit;
        int   i;
        r   = '0;
        hit = -1;
        for (i = 0; i < flow_total; i++)
            if (hit < 0 && flow_addr[i] == addr && flow_port[i] == port)
                hit = i;

        if (op == OP_CLOSE) begin
            if (hit < 0) begin
                r.status = ST_IGNORED;
            end
            else begin
                for (i = hit; i < flow_total - 1; i++) begin
                    flow_addr[i]    = flow_addr[i + 1];
                    flow_port[i]    = flow_port[i + 1];
                    flow_packets[i] = flow_packets[i + 1];
                end
                flow_total--;
                r.status = ST_REMOVED;
            end
        end
        else if (hit < 0 && flow_total >= TABLE_DEPTH) begin
            r.status = ST_FULL;
        end
        else begin
            if (hit < 0) begin
                hit               = flow_total;
                flow_addr[hit]    = addr;
                flow_port[hit]    = port;
                flow_packets[hit] = '0;
                flow_total++;
                r.status = ST_ADDED;
            end
            else begin
                r.status = ST_COUNTED;
            end
            // counter sticks at all ones
            if (flow_packets[hit] != {COUNT_W{1'b1}})
                flow_packets[hit] = flow_packets[hit] + 1'b1;
            r.count = flow_packets[hit];
            r.slot  = SLOT_W'(hit);
        end
        return r;
    endfunction

    always @(posedge clk) begin
        if (rst_n) begin
            if (push && !full)
                expected_results.push_back(apply_packet(operation, source_address, source_port));

            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result with no packet outstanding, status", '0, status);
                end
                else begin
                    oldest = expected_results.pop_front();
                    if (status !== oldest.status)
                        report_mismatch("status", oldest.status, status);
                    if (slot !== oldest.slot)
                        report_mismatch("slot", oldest.slot, slot);
                    if (packet_count !== oldest.count)
                        report_mismatch("packet_count", oldest.count, packet_count);
                end
                result_index++;
            end
            results_outstanding = expected_results.size();
        end
    end

endmodule

/* test/tb.sv */
// ---------------------------------------------------------------------------
// flow table packet counter testbench
// drives packet transactions into the flow table and pops its results under
// changing idle patterns; a checker beside the block predicts and compares
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import ftpc_pkg::*;

    // cycles with no transaction on either side before the run is called dead
    localparam int WATCHDOG_LIMIT  = 8000;
    // long receiver stall used to back the block up into its input
    localparam int HOLD_OFF_CYCLES = 1500;
    // quiet time after the last result, well above a full-table scan
    localparam int DRAIN_CYCLES    = 300;
    localparam int POOL_SIZE       = 24;
    localparam int POOL_ITEMS      = 230;
    localparam int MIXED_ITEMS     = 40;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                push = 1'b0;
    logic                operation = OP_DATA;
    logic [ADDR_W-1:0]   source_address = '0;
    logic [PORT_W-1:0]   source_port = '0;
    logic                pop = 1'b0;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [COUNT_W-1:0]  packet_count;

    int mismatch_count;
    int results_outstanding;

    // idle rates in percent of cycles, changed per phase by the stimulus
    int push_idle_pct = 0;
    int pop_idle_pct  = 0;
    // set by the stimulus, cleared by the receiver when it starts the stall
    bit hold_request  = 1'b0;
    int quiet_cycles  = 0;

    flow_table_packet_counter_unit dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .operation      (operation),
        .source_address (source_address),
        .source_port    (source_port),
        .empty          (empty),
        .pop            (pop),
        .status         (status),
        .slot           (slot),
        .packet_count   (packet_count)
    );

    flow_table_packet_counter_checker u_checker (
        .clk                 (clk),
        .rst_n               (rst_n),
        .push                (push),
        .full                (full),
        .operation           (operation),
        .source_address      (source_address),
        .source_port         (source_port),
        .empty               (empty),
        .pop                 (pop),
        .status              (status),
        .slot                (slot),
        .packet_count        (packet_count),
        .mismatch_count      (mismatch_count),
        .results_outstanding (results_outstanding)
    );

    // 10 ns clock
    initial begin
        forever #5 clk = ~clk;
    end

    // watchdog: any accepted transaction on either side restarts the count
    always @(posedge clk) begin
        if (rst_n) begin
            if ((push && !full) || (pop && !empty))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    // result side: random pop with an occasional long stall on request
    initial begin
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_request) begin
                // the stall is timed here, the sender keeps going meanwhile
                hold_request = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            pop <= ($urandom_range(99) >= pop_idle_pct);
        end
    end

    // offers one packet transaction and returns at the edge where it is taken;
    // push is only lowered when a gap is inserted, so back-to-back transactions
    // keep it high without a second assignment in one step
    task automatic send_packet(input logic op, input logic [ADDR_W-1:0] addr,
                               input logic [PORT_W-1:0] port);
        while ($urandom_range(99) < push_idle_pct) begin
            push <= 1'b0;
            @(posedge clk);
        end
        push           <= 1'b1;
        operation      <= op;
        source_address <= addr;
        source_port    <= port;
        @(posedge clk);
        while (full) @(posedge clk);
    endtask

    // small set of live flows hit over and over, with some noise, then all closed
    task automatic run_pool_traffic();
        logic [ADDR_W-1:0] pool_addr [POOL_SIZE];
        logic [PORT_W-1:0] pool_port [POOL_SIZE];
        logic [ADDR_W-1:0] stray_addr [$];
        logic [PORT_W-1:0] stray_port [$];
        logic [ADDR_W-1:0] a;
        logic [PORT_W-1:0] p;
        int                pick;
        int                k;
        int                n;
        for (k = 0; k < POOL_SIZE; k++) begin
            // some keys share one half with their neighbor so matching needs both
            pool_addr[k] = (k > 0 && $urandom_range(3) == 0) ? pool_addr[k - 1] : $urandom;
            pool_port[k] = (k > 0 && $urandom_range(3) == 0) ? pool_port[k - 1]
                                                                : PORT_W'($urandom);
        end
        for (n = 0; n < POOL_ITEMS; n++) begin
            pick = $urandom_range(99);
            k    = $urandom_range(POOL_SIZE - 1);
            if (pick < 70) begin
                send_packet(OP_DATA, pool_addr[k], pool_port[k]);
            end
            else if (pick < 88) begin
                send_packet(OP_CLOSE, pool_addr[k], pool_port[k]);
            end
            else if (pick < 94) begin
                // unknown flow joins the table, remembered for the cleanup
                a = $urandom;
                p = PORT_W'($urandom);
                stray_addr.push_back(a);
                stray_port.push_back(p);
                send_packet(OP_DATA, a, p);
            end
            else begin
                send_packet(OP_CLOSE, $urandom, PORT_W'($urandom));
            end
        end
        for (k = 0; k < POOL_SIZE; k++)
            send_packet(OP_CLOSE, pool_addr[k], pool_port[k]);
        for (k = 0; k < stray_addr.size(); k++)
            send_packet(OP_CLOSE, stray_addr[k], stray_port[k]);
    endtask

    // fills the empty table past its depth, works it while full, then empties it
    task automatic run_fill_traffic();
        logic [ADDR_W-1:0] fill_addr [$];
        logic [PORT_W-1:0] fill_port [$];
        logic [ADDR_W-1:0] a;
        logic [PORT_W-1:0] p;
        int                pick;
        int                k;
        int                n;
        // the last few new flows find the table full
        for (n = 0; n < TABLE_DEPTH + 8; n++) begin
            a = $urandom;
            p = PORT_W'($urandom);
            fill_addr.push_back(a);
            fill_port.push_back(p);
            send_packet(OP_DATA, a, p);
        end
        for (n = 0; n < MIXED_ITEMS; n++) begin
            pick = $urandom_range(99);
            k    = $urandom_range(fill_addr.size() - 1);
            if (pick < 50) begin
                send_packet(OP_DATA, fill_addr[k], fill_port[k]);
            end
            else if (pick < 75) begin
                send_packet(OP_CLOSE, fill_addr[k], fill_port[k]);
            end
            else begin
                a = $urandom;
                p = PORT_W'($urandom);
                fill_addr.push_back(a);
                fill_port.push_back(p);
                send_packet(OP_DATA, a, p);
            end
        end
        for (k = 0; k < fill_addr.size(); k++)
            send_packet(OP_CLOSE, fill_addr[k], fill_port[k]);
    endtask

    // main stimulus
    initial begin
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        push_idle_pct = 25;
        pop_idle_pct  = 84;

        // directed: empty table, extreme keys, half-matching keys, removal at
        // the head, middle and tail with the shift, unknown closes
        send_packet(OP_CLOSE, 32'h0000_0000, 16'h0000);
        send_packet(OP_DATA,  32'h0000_0000, 16'h0000);
        send_packet(OP_DATA,  32'h0000_0000, 16'h0000);
        send_packet(OP_DATA,  32'hFFFF_FFFF, 16'hFFFF);
        send_packet(OP_DATA,  32'h0000_0000, 16'hFFFF);
        send_packet(OP_DATA,  32'hFFFF_FFFF, 16'h0000);
        send_packet(OP_DATA,  32'hAAAA_AAAA, 16'h5555);
        send_packet(OP_DATA,  32'h5555_5555, 16'hAAAA);
        send_packet(OP_CLOSE, 32'h1234_5678, 16'h55AA);
        send_packet(OP_CLOSE, 32'h0000_0000, 16'hFFFF);
        send_packet(OP_DATA,  32'hFFFF_FFFF, 16'h0000);
        send_packet(OP_CLOSE, 32'h0000_0000, 16'h0000);
        send_packet(OP_DATA,  32'hFFFF_FFFF, 16'hFFFF);
        send_packet(OP_CLOSE, 32'h5555_5555, 16'hAAAA);
        send_packet(OP_CLOSE, 32'h5555_5555, 16'hAAAA);
        send_packet(OP_DATA,  32'hAAAA_AAAA, 16'h5555);
        send_packet(OP_CLOSE, 32'hFFFF_FFFF, 16'hFFFF);
        send_packet(OP_CLOSE, 32'hFFFF_FFFF, 16'h0000);
        send_packet(OP_CLOSE, 32'hAAAA_AAAA, 16'h5555);

        // three idle patterns: slow receiver, slow sender, then full speed
        for (phase = 0; phase < 3; phase++) begin
            if (phase == 0) begin
                push_idle_pct = 25;
                pop_idle_pct  = 84;
            end
            else if (phase == 1) begin
                push_idle_pct = 84;
                pop_idle_pct  = 25;
            end
            else begin
                push_idle_pct = 0;
                pop_idle_pct  = 0;
                // receiver stalls while packets keep coming, block backs up
                hold_request  = 1'b1;
            end
            run_pool_traffic();
            run_fill_traffic();
        end
        push <= 1'b0;

        // sample the checker away from the active edge
        @(negedge clk);
        while (results_outstanding != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/ftpc_pkg.sv
rtl/ftpc_front.sv
rtl/ftpc_result_q.sv
rtl/ftpc_engine.sv
rtl/flow_table_packet_counter_unit.sv
test/flow_table_packet_counter_checker.sv
test/tb.sv
